>>> design/ride_mode_tracker_macros.svh
// Assertion macros for the ride mode tracker.
`ifndef RIDE_MODE_TRACKER_MACROS_SVH
`define RIDE_MODE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

`define RMT_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ride_mode_tracker: next-cycle check failed");

`define RMT_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ride_mode_tracker: same-cycle check failed");

`else

`define RMT_ASSERT_NEXT(lbl, pre, post)
`define RMT_ASSERT_NOW(lbl, pre, post)

`endif

`endif

>>> design/rmt_pkg.sv
package rmt_pkg;

    localparam int unsigned SPEED_W = 12;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [SPEED_W-1:0] RIDE_SPEED_RST = 12'd100;
    localparam logic [SPEED_W-1:0] IDLE_SPEED_RST = 12'd30;
    localparam logic [TIME_W-1:0]  RIDE_CONFIRM_RST = 32'd5000;
    localparam logic [TIME_W-1:0]  IDLE_TIMEOUT_RST = 32'd60000;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_RIDING = 3'd1,
        MODE_IMPACT = 3'd2,
        MODE_FALLEN = 3'd3,
        MODE_SOS    = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        KIND_GPS    = 3'd0,
        KIND_IMPACT = 3'd1,
        KIND_FALL   = 3'd2,
        KIND_SOS    = 3'd3,
        KIND_ACK    = 3'd4,
        KIND_STATUS = 3'd5
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RIDE_SPEED   = 2'd0,
        CFG_IDLE_SPEED   = 2'd1,
        CFG_RIDE_CONFIRM = 2'd2,
        CFG_IDLE_TIMEOUT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SPEED_W-1:0] ride_speed;
        logic [SPEED_W-1:0] idle_speed;
        logic [TIME_W-1:0]  ride_confirm;
        logic [TIME_W-1:0]  idle_timeout;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         kind;
        logic [TIME_W-1:0]  now_ms;
        logic [SPEED_W-1:0] speed;
        logic               gps_valid;
    } t_item;

    typedef struct packed {
        logic [2:0]        mode;
        logic [2:0]        previous_mode;
        logic              detect_enable;
        logic [TIME_W-1:0] time_in_mode;
    } t_result;

endpackage

>>> design/rmt_if.sv
interface rmt_in_if import rmt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [TIME_W-1:0]  now_ms;
    logic [SPEED_W-1:0] speed;
    logic               gps_valid;

    modport source (output valid, kind, now_ms, speed, gps_valid, input ready);
    modport sink   (input valid, kind, now_ms, speed, gps_valid, output ready);
endinterface

interface rmt_out_if import rmt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        mode;
    logic [2:0]        previous_mode;
    logic              detect_enable;
    logic [TIME_W-1:0] time_in_mode;

    modport source (output valid, mode, previous_mode, detect_enable, time_in_mode,
                    input ready);
    modport sink   (input valid, mode, previous_mode, detect_enable, time_in_mode,
                    output ready);
endinterface

interface rmt_cfg_if import rmt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/rmt_fsm.sv
module rmt_fsm import rmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result,
    output t_mode   o_mode
);

    t_mode             r_mode, n_mode;
    t_mode             r_prior, n_prior;
    logic [TIME_W-1:0] r_entry, n_entry;
    logic [TIME_W-1:0] r_last_moving, n_last_moving;
    logic [TIME_W-1:0] r_cand_time, n_cand_time;
    logic              r_cand_act, n_cand_act;

    logic [TIME_W-1:0] cand_age;
    logic [TIME_W-1:0] moving_stamp;
    logic [TIME_W-1:0] still_age;

    assign cand_age     = i_item.now_ms - r_cand_time;
    assign moving_stamp = (i_item.speed > i_cfg.idle_speed) ? i_item.now_ms : r_last_moving;
    assign still_age    = i_item.now_ms - moving_stamp;

    // next state
    always_comb begin
        n_mode        = r_mode;
        n_prior       = r_prior;
        n_entry       = r_entry;
        n_last_moving = r_last_moving;
        n_cand_time   = r_cand_time;
        n_cand_act    = r_cand_act;
        case (i_item.kind)
            KIND_GPS: begin
                if (i_item.gps_valid) begin
                    if (r_mode == MODE_IDLE) begin
                        if (i_item.speed > i_cfg.ride_speed) begin
                            if (!r_cand_act) begin
                                n_cand_act  = 1'b1;
                                n_cand_time = i_item.now_ms;
                            end else if (cand_age > i_cfg.ride_confirm) begin
                                n_prior    = r_mode;
                                n_mode     = MODE_RIDING;
                                n_entry    = i_item.now_ms;
                                n_cand_act = 1'b0;
                            end
                        end else begin
                            n_cand_act = 1'b0;
                        end
                    end else if (r_mode == MODE_RIDING) begin
                        n_last_moving = moving_stamp;
                        if (still_age > i_cfg.idle_timeout) begin
                            n_prior = r_mode;
                            n_mode  = MODE_IDLE;
                            n_entry = i_item.now_ms;
                        end
                    end
                end
            end
            KIND_IMPACT: begin
                if (r_mode == MODE_IDLE || r_mode == MODE_RIDING) begin
                    n_prior = r_mode;
                    n_mode  = MODE_IMPACT;
                    n_entry = i_item.now_ms;
                end
            end
            KIND_FALL: begin
                n_prior = r_mode;
                n_mode  = MODE_FALLEN;
                n_entry = i_item.now_ms;
            end
            KIND_SOS: begin
                n_prior = r_mode;
                n_mode  = MODE_SOS;
                n_entry = i_item.now_ms;
            end
            KIND_ACK: begin
                if (r_mode == MODE_IMPACT || r_mode == MODE_FALLEN) begin
                    n_mode = r_prior;
                end else if (r_mode == MODE_SOS) begin
                    n_mode = MODE_IDLE;
                end
                n_entry = i_item.now_ms;
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_result.mode          = n_mode;
        o_result.previous_mode = n_prior;
        o_result.detect_enable = (n_mode == MODE_IDLE) || (n_mode == MODE_RIDING);
        o_result.time_in_mode  = i_item.now_ms - n_entry;
    end

    assign o_mode = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_prior       <= MODE_IDLE;
            r_entry       <= '0;
            r_last_moving <= '0;
            r_cand_time   <= '0;
            r_cand_act    <= 1'b0;
        end else if (i_accept) begin
            r_mode        <= n_mode;
            r_prior       <= n_prior;
            r_entry       <= n_entry;
            r_last_moving <= n_last_moving;
            r_cand_time   <= n_cand_time;
            r_cand_act    <= n_cand_act;
        end
    end

endmodule

>>> design/ride_mode_tracker.sv
// Channel   Dir  Role    Payload
// i_in      in   sink    kind, now_ms, speed, gps_valid
// o_out     out  source  mode, previous_mode, detect_enable, time_in_mode
// i_cfg     in   sink    index, data (always ready)
//
// One request per cycle unless the receiver stalls; its result appears in the output register the next cycle.
// The mode update and result are one compare-and-subtract pass ahead of that register.
// A new request is taken while the output register is empty or being drained.
// Synchronous reset restores default thresholds and returns the tracker to idle.
`include "ride_mode_tracker_macros.svh"

module ride_mode_tracker import rmt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmt_in_if.sink      i_in,
    rmt_out_if.source   o_out,
    rmt_cfg_if.sink     i_cfg
);

    t_cfg    r_cfg;
    t_item   item;
    t_result result;
    t_result r_res;
    logic    r_out_valid;
    logic    accept;
    t_mode   mode;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;

    assign item.kind      = i_in.kind;
    assign item.now_ms    = i_in.now_ms;
    assign item.speed     = i_in.speed;
    assign item.gps_valid = i_in.gps_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ride_speed   <= RIDE_SPEED_RST;
            r_cfg.idle_speed   <= IDLE_SPEED_RST;
            r_cfg.ride_confirm <= RIDE_CONFIRM_RST;
            r_cfg.idle_timeout <= IDLE_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_RIDE_SPEED:   r_cfg.ride_speed   <= i_cfg.data[SPEED_W-1:0];
                CFG_IDLE_SPEED:   r_cfg.idle_speed   <= i_cfg.data[SPEED_W-1:0];
                CFG_RIDE_CONFIRM: r_cfg.ride_confirm <= i_cfg.data[TIME_W-1:0];
                CFG_IDLE_TIMEOUT: r_cfg.idle_timeout <= i_cfg.data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rmt_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result),
        .o_mode   (mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.mode          = r_res.mode;
    assign o_out.previous_mode = r_res.previous_mode;
    assign o_out.detect_enable = r_res.detect_enable;
    assign o_out.time_in_mode  = r_res.time_in_mode;

    `RMT_ASSERT_NEXT(a_accept_gives_result, accept, o_out.valid && (mode == t_mode'(o_out.mode)))
    `RMT_ASSERT_NEXT(a_sos_entry, accept && (i_in.kind == KIND_SOS), (o_out.mode == MODE_SOS) && (o_out.time_in_mode == '0))
    `RMT_ASSERT_NEXT(a_ack_from_sos, accept && (i_in.kind == KIND_ACK) && (mode == MODE_SOS), (mode == MODE_IDLE) && o_out.detect_enable)
    `RMT_ASSERT_NOW(a_stall_blocks_input, r_out_valid && !o_out.ready, !i_in.ready)

endmodule

>>> verif/ride_mode_tracker_tb.sv
module ride_mode_tracker_tb;
    import rmt_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef struct {
        t_item   it;
        bit      fixed;
        t_result res;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rmt_in_if  in_ch ();
    rmt_out_if out_ch ();
    rmt_cfg_if cfg_ch ();

    ride_mode_tracker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // tracker state as seen from outside
    t_mode              trk_mode    = MODE_IDLE;
    t_mode              trk_prior   = MODE_IDLE;
    logic [TIME_W-1:0]  mode_since  = '0;
    logic [TIME_W-1:0]  moved_at    = '0;
    logic [TIME_W-1:0]  arm_at      = '0;
    logic               armed       = 1'b0;
    logic [SPEED_W-1:0] thr_ride    = RIDE_SPEED_RST;
    logic [SPEED_W-1:0] thr_still   = IDLE_SPEED_RST;
    logic [TIME_W-1:0]  confirm_ms  = RIDE_CONFIRM_RST;
    logic [TIME_W-1:0]  still_limit = IDLE_TIMEOUT_RST;

    t_result           awaited_status [$];
    int                fault_count = 0;
    bit                pend_fixed  = 1'b0;
    t_result           pend_res    = '0;
    logic [TIME_W-1:0] clock_ms    = '0;
    int                burst_left  = 0;

    function automatic void switch_mode(t_mode m, logic [TIME_W-1:0] t);
        trk_prior  = trk_mode;
        trk_mode   = m;
        mode_since = t;
    endfunction

    function automatic t_result advance_tracker(t_item it);
        t_result r;
        case (it.kind)
            KIND_GPS: begin
                if (it.gps_valid) begin
                    if (trk_mode == MODE_IDLE) begin
                        if (it.speed > thr_ride) begin
                            if (!armed) begin
                                armed  = 1'b1;
                                arm_at = it.now_ms;
                            end else if (TIME_W'(it.now_ms - arm_at) > confirm_ms) begin
                                switch_mode(MODE_RIDING, it.now_ms);
                                armed = 1'b0;
                            end
                        end else begin
                            armed = 1'b0;
                        end
                    end else if (trk_mode == MODE_RIDING) begin
                        if (it.speed > thr_still)
                            moved_at = it.now_ms;
                        if (TIME_W'(it.now_ms - moved_at) > still_limit)
                            switch_mode(MODE_IDLE, it.now_ms);
                    end
                end
            end
            KIND_IMPACT: begin
                if (trk_mode == MODE_IDLE || trk_mode == MODE_RIDING)
                    switch_mode(MODE_IMPACT, it.now_ms);
            end
            KIND_FALL:   switch_mode(MODE_FALLEN, it.now_ms);
            KIND_SOS:    switch_mode(MODE_SOS, it.now_ms);
            KIND_ACK: begin
                if (trk_mode == MODE_IMPACT || trk_mode == MODE_FALLEN)
                    trk_mode = trk_prior;
                else if (trk_mode == MODE_SOS)
                    trk_mode = MODE_IDLE;
                mode_since = it.now_ms;
            end
            default: ;
        endcase
        r.mode          = trk_mode;
        r.previous_mode = trk_prior;
        r.detect_enable = (trk_mode == MODE_IDLE || trk_mode == MODE_RIDING);
        r.time_in_mode  = it.now_ms - mode_since;
        return r;
    endfunction

    always @(posedge i_clk) begin : status_check
        t_result want;
        t_result got;
        t_item   req;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.mode          = out_ch.mode;
                got.previous_mode = out_ch.previous_mode;
                got.detect_enable = out_ch.detect_enable;
                got.time_in_mode  = out_ch.time_in_mode;
                if (awaited_status.size() == 0) begin
                    $error("unexpected status: mode %0d time_in_mode %0d",
                           got.mode, got.time_in_mode);
                    fault_count++;
                end else begin
                    want = awaited_status.pop_front();
                    if (got.mode !== want.mode) begin
                        $error("mode: expected %0d, got %0d", want.mode, got.mode);
                        fault_count++;
                    end
                    if (got.previous_mode !== want.previous_mode) begin
                        $error("previous_mode: expected %0d, got %0d",
                               want.previous_mode, got.previous_mode);
                        fault_count++;
                    end
                    if (got.detect_enable !== want.detect_enable) begin
                        $error("detect_enable: expected %0d, got %0d",
                               want.detect_enable, got.detect_enable);
                        fault_count++;
                    end
                    if (got.time_in_mode !== want.time_in_mode) begin
                        $error("time_in_mode: expected %0d, got %0d",
                               want.time_in_mode, got.time_in_mode);
                        fault_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_RIDE_SPEED:   thr_ride    = cfg_ch.data[SPEED_W-1:0];
                    CFG_IDLE_SPEED:   thr_still   = cfg_ch.data[SPEED_W-1:0];
                    CFG_RIDE_CONFIRM: confirm_ms  = cfg_ch.data;
                    CFG_IDLE_TIMEOUT: still_limit = cfg_ch.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                req.kind      = in_ch.kind;
                req.now_ms    = in_ch.now_ms;
                req.speed     = in_ch.speed;
                req.gps_valid = in_ch.gps_valid;
                want = advance_tracker(req);
                awaited_status.push_back(pend_fixed ? pend_res : want);
            end
        end
    end

    // receiver back-pressure, in random styles that change from one random span to the next
    initial begin : sink_stall
        int style;
        int span;
        int hold;
        style = 0;
        span  = 0;
        hold  = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(16, 96);
            end
            span--;
            case (style)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (hold == 0) begin
                        out_ch.ready <= ~out_ch.ready;
                        hold = $urandom_range(1, 10);
                    end
                    hold--;
                end
            endcase
        end
    end

    function automatic t_dir_row mk_row(logic [2:0] k, logic [TIME_W-1:0] t,
                                        logic [SPEED_W-1:0] s, logic g, int f,
                                        t_mode m, t_mode p, logic d,
                                        logic [TIME_W-1:0] tim);
        t_dir_row row;
        row.it.kind                = k;
        row.it.now_ms              = t;
        row.it.speed               = s;
        row.it.gps_valid           = g;
        row.fixed                  = (f != 0);
        row.res.mode               = m;
        row.res.previous_mode      = p;
        row.res.detect_enable      = d;
        row.res.time_in_mode       = tim;
        return row;
    endfunction

    task automatic send_item(t_item it, bit f, t_result r);
        pend_fixed = f;
        pend_res   = r;
        in_ch.kind      <= it.kind;
        in_ch.now_ms    <= it.now_ms;
        in_ch.speed     <= it.speed;
        in_ch.gps_valid <= it.gps_valid;
        in_ch.valid     <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic pause(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (awaited_status.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_regs(logic [CFG_DATA_W-1:0] v [4]);
        for (int i = 0; i < 4; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= t_cfg_idx'(i);
            cfg_ch.data  <= v[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random(int n);
        t_item             it;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] step;
        int                pick;
        for (int i = 0; i < n; i++) begin
            if (burst_left == 0) begin
                pause($urandom_range(1, 8));
                burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (pick < 62)      it.kind = KIND_GPS;
            else if (pick < 69) it.kind = KIND_IMPACT;
            else if (pick < 74) it.kind = KIND_FALL;
            else if (pick < 79) it.kind = KIND_SOS;
            else if (pick < 90) it.kind = KIND_ACK;
            else if (pick < 96) it.kind = KIND_STATUS;
            else                it.kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
            span = $urandom_range(0, 1) ? confirm_ms : still_limit;
            case ($urandom_range(0, 9))
                0:       step = '0;
                1, 2, 3: step = $urandom_range(1, 300);
                4, 5, 6: step = span + $urandom_range(0, 3) - 1;
                7, 8:    step = span >> $urandom_range(1, 6);
                default: step = $urandom;
            endcase
            clock_ms  = clock_ms + step;
            it.now_ms = clock_ms;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    it.speed = (thr_ride == '1) ? '1 :
                               SPEED_W'($urandom_range(int'(thr_ride) + 1, 4095));
                5:       it.speed = thr_ride;
                6:       it.speed = thr_still;
                7:       it.speed = thr_still + 1'b1;
                8:       it.speed = '0;
                default: it.speed = SPEED_W'($urandom);
            endcase
            it.gps_valid = ($urandom_range(0, 9) != 0);
            send_item(it, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        t_dir_row              rows [$];
        logic [CFG_DATA_W-1:0] regs [4];
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_STATUS;
        in_ch.now_ms     = '0;
        in_ch.speed      = '0;
        in_ch.gps_valid  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_RIDE_SPEED;
        cfg_ch.data      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        rows.push_back(mk_row(KIND_STATUS, 32'd0, 12'd0, 1'b0, 1,
                              MODE_IDLE, MODE_IDLE, 1'b1, 32'd0));
        rows.push_back(mk_row(KIND_STATUS, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 1,
                              MODE_IDLE, MODE_IDLE, 1'b1, 32'hFFFF_FFFF));
        // invalid fix changes nothing
        rows.push_back(mk_row(KIND_GPS, 32'd10, 12'hFFF, 1'b0, 1,
                              MODE_IDLE, MODE_IDLE, 1'b1, 32'd10));
        rows.push_back(mk_row(KIND_GPS, 32'd20, 12'd100, 1'b1, 1,
                              MODE_IDLE, MODE_IDLE, 1'b1, 32'd20));
        rows.push_back(mk_row(KIND_GPS, 32'd1000, 12'd101, 1'b1, 1,
                              MODE_IDLE, MODE_IDLE, 1'b1, 32'd1000));
        rows.push_back(mk_row(KIND_GPS, 32'd6000, 12'hFFF, 1'b1, 1,
                              MODE_IDLE, MODE_IDLE, 1'b1, 32'd6000));
        rows.push_back(mk_row(KIND_GPS, 32'd6001, 12'hFFF, 1'b1, 1,
                              MODE_RIDING, MODE_IDLE, 1'b1, 32'd0));
        // moving stamp still zero: riding ends on the first still update
        rows.push_back(mk_row(KIND_GPS, 32'd60002, 12'd0, 1'b1, 1,
                              MODE_IDLE, MODE_RIDING, 1'b1, 32'd0));
        rows.push_back(mk_row(KIND_IMPACT, 32'd60010, 12'd0, 1'b0, 1,
                              MODE_IMPACT, MODE_IDLE, 1'b0, 32'd0));
        rows.push_back(mk_row(KIND_IMPACT, 32'd60020, 12'd0, 1'b0, 1,
                              MODE_IMPACT, MODE_IDLE, 1'b0, 32'd10));
        rows.push_back(mk_row(KIND_GPS, 32'd60030, 12'hFFF, 1'b1, 1,
                              MODE_IMPACT, MODE_IDLE, 1'b0, 32'd20));
        rows.push_back(mk_row(KIND_FALL, 32'd60040, 12'd0, 1'b0, 1,
                              MODE_FALLEN, MODE_IMPACT, 1'b0, 32'd0));
        rows.push_back(mk_row(KIND_FALL, 32'd60050, 12'd0, 1'b0, 1,
                              MODE_FALLEN, MODE_FALLEN, 1'b0, 32'd0));
        // ack returns to prior mode, itself an emergency here
        rows.push_back(mk_row(KIND_ACK, 32'd60060, 12'd0, 1'b0, 1,
                              MODE_FALLEN, MODE_FALLEN, 1'b0, 32'd0));
        rows.push_back(mk_row(KIND_SOS, 32'd60070, 12'd0, 1'b0, 1,
                              MODE_SOS, MODE_FALLEN, 1'b0, 32'd0));
        rows.push_back(mk_row(KIND_SOS, 32'd60080, 12'd0, 1'b0, 1,
                              MODE_SOS, MODE_SOS, 1'b0, 32'd0));
        rows.push_back(mk_row(KIND_ACK, 32'd60090, 12'd0, 1'b0, 1,
                              MODE_IDLE, MODE_SOS, 1'b1, 32'd0));
        rows.push_back(mk_row(KIND_ACK, 32'd60100, 12'd0, 1'b0, 1,
                              MODE_IDLE, MODE_SOS, 1'b1, 32'd0));
        rows.push_back(mk_row(KIND_SPARE_LO, 32'd60150, 12'hFFF, 1'b1, 1,
                              MODE_IDLE, MODE_SOS, 1'b1, 32'd50));
        rows.push_back(mk_row(KIND_SPARE_HI, 32'd60200, 12'hFFF, 1'b1, 1,
                              MODE_IDLE, MODE_SOS, 1'b1, 32'd100));
        // confirm window across the timestamp wrap
        rows.push_back(mk_row(KIND_GPS, 32'hFFFF_F000, 12'd200, 1'b1, 0,
                              MODE_IDLE, MODE_IDLE, 1'b0, 32'd0));
        rows.push_back(mk_row(KIND_GPS, 32'd1024, 12'd200, 1'b1, 1,
                              MODE_RIDING, MODE_IDLE, 1'b1, 32'd0));
        rows.push_back(mk_row(KIND_GPS, 32'd2000, 12'd31, 1'b1, 1,
                              MODE_RIDING, MODE_IDLE, 1'b1, 32'd976));
        rows.push_back(mk_row(KIND_IMPACT, 32'd3000, 12'd0, 1'b0, 1,
                              MODE_IMPACT, MODE_RIDING, 1'b0, 32'd0));
        rows.push_back(mk_row(KIND_ACK, 32'd3500, 12'd0, 1'b0, 1,
                              MODE_RIDING, MODE_RIDING, 1'b1, 32'd0));
        foreach (rows[i])
            send_item(rows[i].it, rows[i].fixed, rows[i].res);
        clock_ms = 32'd3500;

        for (int p = 0; p < 7; p++) begin
            settle();
            case (p)
                0: regs = '{32'd100, 32'd30, 32'd5000, 32'd60000};
                1: regs = '{32'd0, 32'd0, 32'd0, 32'd0};
                2: regs = '{32'hFFF, 32'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                3: regs = '{$urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 2000), $urandom_range(0, 5000)};
                4: regs = '{32'd4094, 32'd1, 32'd1, 32'hFFFF_FFFE};
                5: regs = '{$urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom, $urandom};
                default: regs = '{$urandom_range(0, 300), $urandom_range(0, 300),
                                  $urandom_range(0, 100000), $urandom_range(0, 100000)};
            endcase
            // upper data bits are don't-care for the speed thresholds
            regs[CFG_RIDE_SPEED] |= $urandom & 32'hFFFF_F000;
            regs[CFG_IDLE_SPEED] |= $urandom & 32'hFFFF_F000;
            load_regs(regs);
            @(negedge i_clk);
            send_random(225);
        end
        settle();

        if (fault_count == 0)
            $display("ride_mode_tracker regression: pass");
        else
            $display("ride_mode_tracker regression: fail");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("ride_mode_tracker regression: fail");
        $finish;
    end

endmodule
